FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the mixer checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define AST_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// Widths, codes and fixed-point constants of the differential drive mixer
// ----------------------------------------------------------------------------
package ddm_pkg;

   // field widths
   localparam int STEER_W    = 12;
   localparam int THR_W      = 12;
   localparam int DIR_W      = 2;
   localparam int SPEED_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   // motor direction codes
   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED  = 1'b1;

   localparam logic [CSR_DATA_W-1:0] MAX_SPEED_RESET = 10'd10;
   localparam logic [CSR_DATA_W-1:0] MAX_SPEED_LIMIT = 10'd1000;

   // pulse scale and heading limits
   localparam logic signed [STEER_W-1:0] RC_LOW    = 12'sd1000;
   localparam logic signed [STEER_W-1:0] RC_HIGH   = 12'sd2000;
   localparam logic signed [STEER_W-1:0] HDG_LIMIT = 12'sd180;

   // offset from 1000 on the pulse scale, 0..1000
   localparam int U_W = 10;
   localparam logic [U_W-1:0] U_FULL = 10'd1000;

   // heading offset 0..360
   localparam int HDG_W = 9;
   localparam logic [HDG_W-1:0] HDG_SPAN = 9'd360;

   // heading steer: floor(t*25/9) as (t * 25 * ceil(2^20/9)) >> 20
   localparam int HDG_PROD_W  = 31;
   localparam int HDG_SHIFT   = 20;
   localparam logic [21:0] HDG_STEER_MUL = 22'd2912725;

   // heading throttle: floor(n*500/m) through the divider
   localparam int NT_W   = 11;
   localparam int NUM_W  = 20;
   localparam int DEN_W  = 10;
   localparam int QUOT_W = 10;
   localparam logic [8:0] THR_SCALE = 9'd500;

   // axis: floor(u*32/125) as (u * 32 * ceil(2^24/125)) >> 24, minus 128
   localparam int AXIS_W      = 9;
   localparam int AXIS_PROD_W = 33;
   localparam int AXIS_SHIFT  = 24;
   localparam logic [22:0] AXIS_MUL = 23'd4294976;
   localparam logic signed [AXIS_W:0] AXIS_BIAS = 10'sd128;

   // mix arithmetic
   localparam int PIVOT_W  = 6;
   localparam logic [PIVOT_W-1:0] PIVOT_LIMIT = 6'd32;
   localparam int PREMIX_W = 8;
   localparam int APL_W    = 13;
   localparam int CX_W     = 14;
   localparam int MIX_W    = 22;
   localparam int CX_SHIFT = 7;
   localparam int ROUND_SHIFT = 12;
   localparam logic [ROUND_SHIFT-1:0] ROUND_HALF = 12'd2048;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

   // sideband carried alongside the divider
   typedef struct packed {
      logic           mode;
      logic [U_W-1:0] ud;
      logic [U_W-1:0] us_rc;
   } ddm_side_type;

endpackage

FILE: src/ddm_if.sv
// ----------------------------------------------------------------------------
// ddm_if
// Valid/ready channels of the mixer: command, result and register write
// ----------------------------------------------------------------------------

// command channel
interface ddm_req_if;
   import ddm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [STEER_W-1:0] steer;
   logic signed [THR_W-1:0]   throttle;
   modport source (output valid, output steer, output throttle, input ready);
   modport sink   (input valid, input steer, input throttle, output ready);
endinterface

// result channel
interface ddm_rsp_if;
   import ddm_pkg::*;
   logic               valid;
   logic               ready;
   logic [DIR_W-1:0]   left_dir;
   logic [SPEED_W-1:0] left_speed;
   logic [DIR_W-1:0]   right_dir;
   logic [SPEED_W-1:0] right_speed;
   modport source (output valid, output left_dir, output left_speed,
                   output right_dir, output right_speed, input ready);
   modport sink   (input valid, input left_dir, input left_speed,
                   input right_dir, input right_speed, output ready);
endinterface

// register write channel
interface ddm_csr_if;
   import ddm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/ddm_divider.sv
// ----------------------------------------------------------------------------
// ddm_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module ddm_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [ddm_pkg::NUM_W-1:0]    in_num,
   input  logic [ddm_pkg::DEN_W-1:0]    in_den,
   input  ddm_pkg::ddm_side_type        in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [ddm_pkg::QUOT_W-1:0]   out_quot,
   output ddm_pkg::ddm_side_type        out_side
);
   import ddm_pkg::*;

   logic [QUOT_W-1:0]  valid_ff;
   logic [NUM_W-1:0]   rem_ff  [QUOT_W];
   logic [QUOT_W-1:0]  quot_ff [QUOT_W];
   logic [DEN_W-1:0]   den_ff  [QUOT_W];
   ddm_side_type       side_ff [QUOT_W];

   logic [QUOT_W-1:0]  stage_en;
   logic [QUOT_W-1:0]  src_valid;
   logic [NUM_W-1:0]   src_rem  [QUOT_W];
   logic [QUOT_W-1:0]  src_quot [QUOT_W];
   logic [DEN_W-1:0]   src_den  [QUOT_W];
   ddm_side_type       src_side [QUOT_W];

   // stage enables ripple back from the output
   always_comb begin
      stage_en[QUOT_W-1] = !valid_ff[QUOT_W-1] || out_ready;
      for (int k = QUOT_W - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // each stage reads the stage before it, the first reads the inputs
   always_comb begin
      src_valid[0] = in_valid;
      src_rem[0]   = in_num;
      src_quot[0]  = '0;
      src_den[0]   = in_den;
      src_side[0]  = in_side;
      for (int k = 1; k < QUOT_W; k++) begin
         src_valid[k] = valid_ff[k-1];
         src_rem[k]   = rem_ff[k-1];
         src_quot[k]  = quot_ff[k-1];
         src_den[k]   = den_ff[k-1];
         src_side[k]  = side_ff[k-1];
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int BIT = QUOT_W - 1 - k;

      logic [NUM_W-1:0]  den_shift;
      logic [NUM_W:0]    trial;
      logic [NUM_W-1:0]  rem_in;
      logic [QUOT_W-1:0] quot_in;

      // trial subtract of the shifted divisor
      always_comb begin
         den_shift    = NUM_W'(src_den[k]) << BIT;
         trial        = {1'b0, src_rem[k]} - {1'b0, den_shift};
         rem_in       = trial[NUM_W] ? src_rem[k] : trial[NUM_W-1:0];
         quot_in      = src_quot[k];
         quot_in[BIT] = !trial[NUM_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_en[k]) begin
            valid_ff[k] <= src_valid[k];
         end
         if (stage_en[k]) begin
            rem_ff[k]  <= rem_in;
            quot_ff[k] <= quot_in;
            den_ff[k]  <= src_den[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

FILE: src/differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Differential-steering mixer: steer and throttle to two motor commands
// ----------------------------------------------------------------------------
// Takes one steer/throttle command per clock while the result channel keeps
// up, and returns one result per command, in order. The depth is set mostly
// by the ten-stage restoring divider that rescales the throttle by max_speed
// in heading mode; the remaining stages clamp and pre-scale, map both
// commands to the -128..128 axis, form the premix and pivot products, sum the
// mix, and round and saturate into the output register. Each stage holds its
// item until the next stage frees up, so bubbles are squeezed out and a new
// command is taken whenever any stage has room. Register writes are meant for
// an idle block; there is no start-up sweep, the block takes commands from the
// first cycle after reset.
module differential_drive_mixer (
   input  logic     clock,
   input  logic     reset,
   ddm_req_if.sink  req_chan,
   ddm_rsp_if.source rsp_chan,
   ddm_csr_if.sink  csr_chan
);
   import ddm_pkg::*;

   typedef struct packed {
      logic [DIR_W-1:0]   dir;
      logic [SPEED_W-1:0] speed;
   } motor_type;

   // round n/4096 half to even, then duty 2|m|-1 saturated
   function automatic motor_type motor_drive(input logic signed [MIX_W-1:0] n);
      logic signed [MIX_W-ROUND_SHIFT-1:0] q;
      logic [ROUND_SHIFT-1:0]              r;
      logic signed [MIX_W-ROUND_SHIFT:0]   m;
      logic [MIX_W-ROUND_SHIFT:0]          mag;
      motor_type                           res;
      q = n[MIX_W-1:ROUND_SHIFT];
      r = n[ROUND_SHIFT-1:0];
      m = (MIX_W-ROUND_SHIFT+1)'(q);
      if (r > ROUND_HALF || (r == ROUND_HALF && q[0])) begin
         m = m + 2'sd1;
      end
      mag = (m < 0) ? -m : m;
      if (m == 0) begin
         res.dir   = DIR_STOP;
         res.speed = '0;
      end else begin
         res.dir = (m > 0) ? DIR_FWD : DIR_BWD;
         if (mag >= (MIX_W-ROUND_SHIFT+1)'(128)) begin
            res.speed = SPEED_MAX;
         end else begin
            res.speed = {mag[SPEED_W-2:0], 1'b0} - 8'd1;
         end
      end
      return res;
   endfunction

   // offset 0..1000 on the pulse scale to the -128..128 axis
   function automatic logic signed [AXIS_W-1:0] to_axis(input logic [U_W-1:0] u);
      logic [AXIS_PROD_W-1:0] prod;
      logic signed [AXIS_W:0] wide;
      prod = AXIS_PROD_W'(u) * AXIS_PROD_W'(AXIS_MUL);
      wide = $signed({1'b0, prod[AXIS_SHIFT +: AXIS_W]}) - AXIS_BIAS;
      return wide[AXIS_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic                  input_mode_ff;
   logic [CSR_DATA_W-1:0] max_speed_ff;

   assign csr_chan.ready = 1'b1;

   // register write transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         input_mode_ff <= 1'b0;
         max_speed_ff  <= MAX_SPEED_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_INPUT_MODE: input_mode_ff <= csr_chan.data[0];
            CSR_MAX_SPEED:  max_speed_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage enables
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en;
   logic div_in_ready, div_out_valid;

   assign s6_en = !s6_valid_ff || rsp_chan.ready;
   assign s5_en = !s5_valid_ff || s6_en;
   assign s4_en = !s4_valid_ff || s5_en;
   assign s3_en = !s3_valid_ff || s4_en;
   assign s2_en = !s2_valid_ff || div_in_ready;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;

   // ------------------------------------------------------------------
   // stage 1: clamp commands to their range for the mode
   // ------------------------------------------------------------------
   logic                  s1_mode_ff;
   logic [U_W-1:0]        s1_ud_rc_ff, s1_us_rc_ff;
   logic [HDG_W-1:0]      s1_hdg_ff;
   logic [NT_W-1:0]       s1_nt_ff;
   logic [DEN_W-1:0]      s1_den_ff;

   logic [U_W-1:0]        ud_rc_in, us_rc_in;
   logic [HDG_W-1:0]      hdg_in;
   logic [NT_W-1:0]       nt_in;
   logic [DEN_W-1:0]      den_in;
   logic signed [STEER_W-1:0] steer_diff, thr_diff, hdg_sum;
   logic signed [THR_W:0] thr_ext, m_ext, nt_sum;

   always_comb begin
      // effective full-scale speed
      if (max_speed_ff == '0) begin
         den_in = 10'd1;
      end else if (max_speed_ff > MAX_SPEED_LIMIT) begin
         den_in = MAX_SPEED_LIMIT;
      end else begin
         den_in = max_speed_ff;
      end

      // pulse widths
      steer_diff = req_chan.steer - RC_LOW;
      thr_diff   = req_chan.throttle - RC_LOW;
      if (req_chan.steer < RC_LOW) begin
         ud_rc_in = '0;
      end else if (req_chan.steer > RC_HIGH) begin
         ud_rc_in = U_FULL;
      end else begin
         ud_rc_in = steer_diff[U_W-1:0];
      end
      if (req_chan.throttle < RC_LOW) begin
         us_rc_in = '0;
      end else if (req_chan.throttle > RC_HIGH) begin
         us_rc_in = U_FULL;
      end else begin
         us_rc_in = thr_diff[U_W-1:0];
      end

      // heading, offset to 0..360
      hdg_sum = req_chan.steer + HDG_LIMIT;
      if (req_chan.steer < -HDG_LIMIT) begin
         hdg_in = '0;
      end else if (req_chan.steer > HDG_LIMIT) begin
         hdg_in = HDG_SPAN;
      end else begin
         hdg_in = hdg_sum[HDG_W-1:0];
      end

      // signed speed, offset to 0..2*max_speed
      thr_ext = (THR_W+1)'(req_chan.throttle);
      m_ext   = $signed({3'b000, den_in});
      nt_sum  = thr_ext + m_ext;
      if (thr_ext < -m_ext) begin
         nt_in = '0;
      end else if (thr_ext > m_ext) begin
         nt_in = {den_in, 1'b0};
      end else begin
         nt_in = nt_sum[NT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (s1_en) begin
         s1_mode_ff  <= input_mode_ff;
         s1_ud_rc_ff <= ud_rc_in;
         s1_us_rc_ff <= us_rc_in;
         s1_hdg_ff   <= hdg_in;
         s1_nt_ff    <= nt_in;
         s1_den_ff   <= den_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: heading steer rescale and throttle numerator
   // ------------------------------------------------------------------
   ddm_side_type          s2_side_ff;
   logic [NUM_W-1:0]      s2_num_ff;
   logic [DEN_W-1:0]      s2_den_ff;

   logic [HDG_PROD_W-1:0] hdg_prod;
   ddm_side_type          side_in;
   logic [NUM_W-1:0]      num_in;

   always_comb begin
      hdg_prod      = HDG_PROD_W'(s1_hdg_ff) * HDG_PROD_W'(HDG_STEER_MUL);
      num_in        = NUM_W'(s1_nt_ff) * NUM_W'(THR_SCALE);
      side_in.mode  = s1_mode_ff;
      side_in.ud    = s1_mode_ff ? hdg_prod[HDG_SHIFT +: U_W] : s1_ud_rc_ff;
      side_in.us_rc = s1_us_rc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_en) begin
         s2_side_ff <= side_in;
         s2_num_ff  <= num_in;
         s2_den_ff  <= s1_den_ff;
      end
   end

   // ------------------------------------------------------------------
   // throttle rescale divider
   // ------------------------------------------------------------------
   logic [QUOT_W-1:0] div_quot;
   ddm_side_type      div_side;

   ddm_divider u_ddm_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (div_in_ready),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_side   (s2_side_ff),
      .out_valid (div_out_valid),
      .out_ready (s3_en),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // ------------------------------------------------------------------
   // stage 3: map both commands to the axis
   // ------------------------------------------------------------------
   logic signed [AXIS_W-1:0] s3_x_ff, s3_y_ff;
   logic [U_W-1:0]           us_sel;

   assign us_sel = div_side.mode ? div_quot : div_side.us_rc;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= div_out_valid;
      end
      if (s3_en) begin
         s3_x_ff <= to_axis(div_side.ud);
         s3_y_ff <= to_axis(us_sel);
      end
   end

   // ------------------------------------------------------------------
   // stage 4: premix, pivot weight and first products
   // ------------------------------------------------------------------
   logic signed [APL_W-1:0]  s4_apl_ff, s4_apr_ff;
   logic signed [CX_W-1:0]   s4_cx_ff;
   logic signed [AXIS_W-1:0] s4_y_ff;

   logic signed [AXIS_W:0]    x_plus, x_minus;
   logic signed [AXIS_W-1:0]  abs_y;
   logic [PIVOT_W-1:0]        pivot_a, pivot_b;
   logic signed [PREMIX_W-1:0] pl, pr, p_plus, p_minus;
   logic signed [APL_W-1:0]   apl_in, apr_in;
   logic signed [CX_W-1:0]    cx_in;

   always_comb begin
      x_plus  = 10'sd127 + (AXIS_W+1)'(s3_x_ff);
      x_minus = 10'sd127 - (AXIS_W+1)'(s3_x_ff);
      p_plus  = x_plus[PREMIX_W-1:0];
      p_minus = x_minus[PREMIX_W-1:0];

      // forward or reverse premix
      if (s3_y_ff >= 0) begin
         pl = (s3_x_ff >= 0) ? 8'sd127 : p_plus;
         pr = (s3_x_ff >= 0) ? p_minus : 8'sd127;
      end else begin
         pl = (s3_x_ff >= 0) ? p_minus : 8'sd127;
         pr = (s3_x_ff >= 0) ? 8'sd127 : p_plus;
      end

      // pivot weight: |y| limited to 32
      abs_y = (s3_y_ff < 0) ? -s3_y_ff : s3_y_ff;
      if (abs_y > $signed({3'b000, PIVOT_LIMIT})) begin
         pivot_a = PIVOT_LIMIT;
      end else begin
         pivot_a = abs_y[PIVOT_W-1:0];
      end
      pivot_b = PIVOT_LIMIT - pivot_a;

      apl_in = APL_W'(signed'({1'b0, pivot_a})) * APL_W'(pl);
      apr_in = APL_W'(signed'({1'b0, pivot_a})) * APL_W'(pr);
      cx_in  = CX_W'(signed'({1'b0, pivot_b})) * CX_W'(s3_x_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_en) begin
         s4_apl_ff <= apl_in;
         s4_apr_ff <= apr_in;
         s4_cx_ff  <= cx_in;
         s4_y_ff   <= s3_y_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: mix numerators over 4096
   // ------------------------------------------------------------------
   logic signed [MIX_W-1:0] s5_nl_ff, s5_nr_ff;
   logic signed [MIX_W-1:0] pivot_term, nl_in, nr_in;

   always_comb begin
      pivot_term = MIX_W'(s4_cx_ff) <<< CX_SHIFT;
      nl_in = MIX_W'(s4_apl_ff) * MIX_W'(s4_y_ff) + pivot_term;
      nr_in = MIX_W'(s4_apr_ff) * MIX_W'(s4_y_ff) - pivot_term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_en) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (s5_en) begin
         s5_nl_ff <= nl_in;
         s5_nr_ff <= nr_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: rounding, direction and duty into the output register
   // ------------------------------------------------------------------
   motor_type s6_left_ff, s6_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (s6_en) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (s6_en) begin
         s6_left_ff  <= motor_drive(s5_nl_ff);
         s6_right_ff <= motor_drive(s5_nr_ff);
      end
   end

   // result transaction
   assign rsp_chan.valid       = s6_valid_ff;
   assign rsp_chan.left_dir    = s6_left_ff.dir;
   assign rsp_chan.left_speed  = s6_left_ff.speed;
   assign rsp_chan.right_dir   = s6_right_ff.dir;
   assign rsp_chan.right_speed = s6_right_ff.speed;

endmodule

FILE: src/ddm_checker.sv
// ----------------------------------------------------------------------------
// ddm_checker
// Port-level checks of the mixer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ddm_pkg::DIR_W-1:0]     left_dir,
   input logic [ddm_pkg::SPEED_W-1:0]   left_speed,
   input logic [ddm_pkg::DIR_W-1:0]     right_dir,
   input logic [ddm_pkg::SPEED_W-1:0]   right_speed
);
   import ddm_pkg::*;

   logic [4:0] pending_ff;
   logic [4:0] pending_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // transactions accepted and not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 5'd1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result without an accepted command
   `AST_IMPLY(a_no_spurious, clock, reset, rsp_valid, pending_ff != 5'd0)

   // a stopped motor has zero duty and a driven one does not
   `AST_IMPLY(a_left_stop, clock, reset, rsp_valid, (left_dir == DIR_STOP) == (left_speed == 8'd0))
   `AST_IMPLY(a_right_stop, clock, reset, rsp_valid, (right_dir == DIR_STOP) == (right_speed == 8'd0))

   // stalled result holds
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(left_dir) && $stable(left_speed) && $stable(right_dir) && $stable(right_speed))

endmodule

bind differential_drive_mixer ddm_checker u_ddm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .left_dir    (rsp_chan.left_dir),
   .left_speed  (rsp_chan.left_speed),
   .right_dir   (rsp_chan.right_dir),
   .right_speed (rsp_chan.right_speed)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the differential drive mixer
// ----------------------------------------------------------------------------
// Steer/throttle commands are fed from a backlog queue by a clocked driver.
// A clocked monitor takes the motor commands with random back-pressure.
// Every accepted command is run through a behavioural mixer kept in the bench,
// and the monitor checks each returned transaction against the oldest
// prediction. The run starts with hand-picked commands in both input modes,
// then goes through several register settings with random commands,
// max_speed extremes and out-of-range values among them.
// ----------------------------------------------------------------------------
module tb;
   import ddm_pkg::*;

   // mixer constants
   localparam int PREMIX_TOP = 127;
   localparam int PIVOT_SPAN = 32;
   localparam int AXIS_SPAN  = 128;
   localparam int MIX_DENOM  = 4096;
   localparam int DUTY_TOP   = 255;
   localparam int RC_MIN     = 1000;
   localparam int RC_MAX     = 2000;
   localparam int HDG_MAX    = 180;
   localparam int PHASES     = 8;
   localparam int PHASE_CMDS = 215;
   localparam int SETTLE_CYC = 24;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic signed [STEER_W-1:0] steer;
      logic signed [THR_W-1:0]   throttle;
   } drive_cmd_type;

   typedef struct packed {
      logic [DIR_W-1:0]   left_dir;
      logic [SPEED_W-1:0] left_speed;
      logic [DIR_W-1:0]   right_dir;
      logic [SPEED_W-1:0] right_speed;
   } motor_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddm_req_if req_chan ();
   ddm_rsp_if rsp_chan ();
   ddm_csr_if csr_chan ();

   differential_drive_mixer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // bench copy of the registers
   logic               cfg_heading   = 1'b0;
   logic [CSR_DATA_W-1:0] cfg_max_speed = MAX_SPEED_RESET;

   drive_cmd_type  cmd_backlog[$];
   motor_pair_type motor_cmds_due[$];
   bit             bursts_on = 1'b1;
   int             send_gap  = 0;
   int             take_hold = 0;
   int             fault_count = 0;
   drive_cmd_type  next_cmd;
   motor_pair_type due_cmd;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // behavioural mixer
   // ---------------------------------------------------------------------------
   function automatic int clamp_int(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int speed_span(logic [CSR_DATA_W-1:0] ms);
      return clamp_int(int'(ms), 1, 1000);
   endfunction

   // integer rescale, truncating toward zero
   function automatic int rescale(int v, int i0, int i1, int o0, int o1);
      return (v - i0) * (o1 - o0) / (i1 - i0) + o0;
   endfunction

   // n / 4096 rounded half to even
   function automatic int round_mix(int n);
      int q;
      int r;
      q = n / MIX_DENOM;
      r = n % MIX_DENOM;
      if (r < 0) begin
         q = q - 1;
         r = r + MIX_DENOM;
      end
      if (r > MIX_DENOM / 2 || (r == MIX_DENOM / 2 && q[0])) q = q + 1;
      return q;
   endfunction

   function automatic logic [DIR_W+SPEED_W-1:0] motor_drive(int m);
      int duty;
      duty = 2 * ((m < 0) ? -m : m) - 1;
      if (duty > DUTY_TOP) duty = DUTY_TOP;
      if (m == 0) return {DIR_STOP, 8'd0};
      return {(m > 0) ? DIR_FWD : DIR_BWD, duty[SPEED_W-1:0]};
   endfunction

   function automatic motor_pair_type mix_motors(drive_cmd_type c);
      int st, th, lim, d, s, x, y, a, pl, pr, nl, nr;
      motor_pair_type res;
      st = int'(c.steer);
      th = int'(c.throttle);
      if (cfg_heading) begin
         lim = speed_span(cfg_max_speed);
         st = clamp_int(st, -HDG_MAX, HDG_MAX);
         th = clamp_int(th, -lim, lim);
         d = rescale(st, -HDG_MAX, HDG_MAX, RC_MIN, RC_MAX);
         s = rescale(th, -lim, lim, RC_MIN, RC_MAX);
      end else begin
         d = clamp_int(st, RC_MIN, RC_MAX);
         s = clamp_int(th, RC_MIN, RC_MAX);
      end
      x = rescale(d, RC_MIN, RC_MAX, -AXIS_SPAN, AXIS_SPAN);
      y = rescale(s, RC_MIN, RC_MAX, -AXIS_SPAN, AXIS_SPAN);
      // premix, mirrored for reverse
      if (y >= 0) begin
         pl = (x >= 0) ? PREMIX_TOP : PREMIX_TOP + x;
         pr = (x >= 0) ? PREMIX_TOP - x : PREMIX_TOP;
      end else begin
         pl = (x >= 0) ? PREMIX_TOP - x : PREMIX_TOP;
         pr = (x >= 0) ? PREMIX_TOP : PREMIX_TOP + x;
      end
      // pivot blend near zero throttle
      a = clamp_int((y < 0) ? -y : y, 0, PIVOT_SPAN);
      nl = a * pl * y + AXIS_SPAN * (PIVOT_SPAN - a) * x;
      nr = a * pr * y - AXIS_SPAN * (PIVOT_SPAN - a) * x;
      {res.left_dir, res.left_speed}   = motor_drive(round_mix(nl));
      {res.right_dir, res.right_speed} = motor_drive(round_mix(nr));
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // command driver
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid    <= 1'b0;
         req_chan.steer    <= '0;
         req_chan.throttle <= '0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            motor_cmds_due.push_back(mix_motors({req_chan.steer, req_chan.throttle}));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               next_cmd = cmd_backlog.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.steer    <= next_cmd.steer;
               req_chan.throttle <= next_cmd.throttle;
               if (bursts_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result monitor
   // ---------------------------------------------------------------------------
   task automatic check_field(string fname, int want, int got);
      if (want != got) begin
         if (fault_count < REPORT_MAX)
            $display("tb: %s mismatch, expected %0d, got %0d", fname, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_hold = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (motor_cmds_due.size() == 0) begin
               if (fault_count < REPORT_MAX)
                  $display("tb: motor command with none outstanding");
               fault_count++;
            end else begin
               due_cmd = motor_cmds_due.pop_front();
               check_field("left_dir", int'(due_cmd.left_dir), int'(rsp_chan.left_dir));
               check_field("left_speed", int'(due_cmd.left_speed),
                           int'(rsp_chan.left_speed));
               check_field("right_dir", int'(due_cmd.right_dir),
                           int'(rsp_chan.right_dir));
               check_field("right_speed", int'(due_cmd.right_speed),
                           int'(rsp_chan.right_speed));
            end
         end
         // back-pressure in short bursts
         if (take_hold > 0) begin
            take_hold = take_hold - 1;
            rsp_chan.ready <= 1'b0;
         end else if (bursts_on && $urandom_range(0, 6) == 0) begin
            take_hold = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   task automatic queue_cmd(int st, int th);
      drive_cmd_type c;
      c.steer    = STEER_W'(st);
      c.throttle = THR_W'(th);
      cmd_backlog.push_back(c);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_INPUT_MODE) cfg_heading = val[0];
      else if (idx == CSR_MAX_SPEED) cfg_max_speed = val;
   endtask

   // block idle: nothing queued, nothing in flight, pipeline settled
   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_chan.valid || motor_cmds_due.size() != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   initial begin
      logic phase_mode[PHASES];
      int   phase_speed[PHASES];
      int   lim;
      int   pick;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = CSR_INPUT_MODE;
      csr_chan.data     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // pulse-width mode at reset settings
      queue_cmd(1500, 1500);          // centred sticks, zero mix
      queue_cmd(2000, 2000);          // full forward corner
      queue_cmd(1000, 1000);
      queue_cmd(2000, 1000);
      queue_cmd(1000, 2000);
      queue_cmd(1500, 2000);
      queue_cmd(1500, 1000);
      queue_cmd(2000, 1500);          // pure pivot
      queue_cmd(1000, 1500);
      queue_cmd(-2048, 2047);         // clamping at both field extremes
      queue_cmd(2047, -2048);
      queue_cmd(0, -1);
      queue_cmd(1520, 1530);          // pivot blend
      queue_cmd(1500, 1502);
      wait_drained();

      // heading mode, default max_speed
      write_reg(CSR_INPUT_MODE, 10'd1);
      queue_cmd(0, 0);
      queue_cmd(180, 10);
      queue_cmd(-180, -10);
      queue_cmd(90, 5);
      queue_cmd(-90, -3);
      queue_cmd(181, 11);             // heading and speed clamp
      queue_cmd(-2048, 2047);
      queue_cmd(45, 1);
      queue_cmd(-1, -1);
      queue_cmd(180, 0);
      queue_cmd(0, -10);
      wait_drained();

      // random phases over register settings, max_speed extremes included
      phase_mode  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      phase_speed = '{1023, 1, 1000, 0, 1023, $urandom_range(1, 1000),
                      $urandom_range(1, 1000), $urandom_range(1, 1000)};
      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_INPUT_MODE, {9'd0, phase_mode[p]});
         write_reg(CSR_MAX_SPEED, CSR_DATA_W'(phase_speed[p]));
         bursts_on = (p != PHASES - 1);
         lim = speed_span(cfg_max_speed);
         for (int n = 0; n < PHASE_CMDS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               // any bit pattern
               queue_cmd(int'($signed(12'($urandom_range(0, 4095)))),
                         int'($signed(12'($urandom_range(0, 4095)))));
            end else if (!cfg_heading) begin
               if (pick < 5)
                  queue_cmd($urandom_range(RC_MIN, RC_MAX), $urandom_range(1440, 1560));
               else
                  queue_cmd($urandom_range(RC_MIN, RC_MAX), $urandom_range(RC_MIN, RC_MAX));
            end else begin
               if (pick < 5)
                  queue_cmd(int'($urandom_range(0, 2 * HDG_MAX)) - HDG_MAX,
                            int'($urandom_range(0, 2 * lim)) - lim
                            - (int'($urandom_range(0, 2 * lim)) - lim) / 2);
               else
                  queue_cmd(int'($urandom_range(0, 2 * HDG_MAX)) - HDG_MAX,
                            int'($urandom_range(0, 2 * lim)) - lim);
            end
         end
         wait_drained();
      end

      if (fault_count == 0 && motor_cmds_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end

endmodule
